// ===== design/tcf_pkg.sv =====
package tcf_pkg;

  // field widths
  localparam int ACC_W     = 24;
  localparam int GYRO_W    = 16;
  localparam int DT_W      = 16;
  localparam int OUT_W     = 24;
  localparam int FRAC_W    = 16;
  localparam int ANGLE_W   = ACC_W + FRAC_W;

  // configuration registers
  localparam int OFFSET_W  = 16;
  localparam int TC_W      = 24;
  localparam int GAIN_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_CONSTANT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN     = 2'd2;

  localparam logic [OFFSET_W-1:0] OFFSET_RST = 16'd0;
  localparam logic [TC_W-1:0]     TC_RST     = 24'd16777;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 32'd3278;

  // internal datapath widths
  localparam int ERR_W  = ANGLE_W + 1;   // accel*2^16 - angle
  localparam int TERM_W = 59;            // a*dt + c + d, and angle + term*dt
  localparam int TMAG_W = 41;            // clamped term magnitude
  localparam logic [TMAG_W-1:0] TERM_LIM = 41'h100_0000_0000;

endpackage

// ===== design/tilt_complementary_filter.sv =====
// tilt complementary filter
// in channel: in_valid/in_ready with in_accel_angle (signed scaled degrees),
// in_gyro_raw (signed raw rate) and in_elapsed_ms (dt). one transfer per sample.
// out channel: out_valid/out_ready with out_filtered_angle, the integer part
// (truncated toward zero) of the fused Q24.16 angle. one result per sample.
// config: cfg_we/cfg_index/cfg_wdata write gyro_offset, time_constant and
// gyro_gain; write only while the block is idle, unknown indexes are ignored.
// the block takes one sample at a time; in_ready is high only in idle, so each
// sample runs its whole step sequence before the next is taken: ten passes
// through the single shared 32x32 multiplier (tc^2, err*tc, err*tc^2,
// gyro*gain, a*dt, term*dt; 41-bit operands in two 32-bit halves) plus
// error, clamp and saturate steps.
// a finished result sits in the output register; if the receiver stalls, the
// next sample still runs but holds in its last step until that register frees.
// reset (synchronous, rst_n low): angle cleared, registers back to defaults,
// no result pending.
module tilt_complementary_filter (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [tcf_pkg::ACC_W-1:0]       in_accel_angle,
  input  logic signed [tcf_pkg::GYRO_W-1:0]      in_gyro_raw,
  input  logic        [tcf_pkg::DT_W-1:0]        in_elapsed_ms,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [tcf_pkg::OUT_W-1:0]       out_filtered_angle,
  input  logic                                   cfg_we,
  input  logic        [tcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [tcf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tcf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_C0, S_C1, S_C2, S_A1, S_A2, S_D,
    S_B1, S_B2, S_T, S_M0, S_M1, S_M2, S_SAT
  } state_t;

  // integer part toward zero: bias negatives by 2^16-1 before the shift
  function automatic logic [OUT_W-1:0] int_part(input logic [ANGLE_W-1:0] x);
    logic [ANGLE_W-1:0] biased;
    biased = x + {{(ANGLE_W-FRAC_W){1'b0}}, {FRAC_W{x[ANGLE_W-1]}}};
    return biased[ANGLE_W-1:FRAC_W];
  endfunction

  state_t state_r;

  // config registers
  logic [OFFSET_W-1:0] offset_r;
  logic [TC_W-1:0]     tc_r;
  logic [GAIN_W-1:0]   gain_r;

  // filter state and output register
  logic [ANGLE_W-1:0]  fused_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_angle_r;

  // sample registers
  logic [ACC_W-1:0]    acc_in_r;
  logic [GYRO_W-1:0]   gyro_in_r;
  logic [DT_W-1:0]     dt_r;

  // working registers
  logic [ERR_W-1:0]    err_mag_r;
  logic                err_neg_r;
  logic [GYRO_W-1:0]   gy_mag_r;
  logic                gy_neg_r;
  logic [TC_W-1:0]     tc2_r;
  logic [63:0]         lo_r;
  logic [ERR_W-1:0]    c_mag_r;
  logic [ANGLE_W-1:0]  a_mag_r;
  logic [31:0]         d_mag_r;
  logic [TERM_W-1:0]   term_r;
  logic [TMAG_W-1:0]   tmag_r;
  logic                tneg_r;
  logic [TERM_W-1:0]   next_r;

  // shared multiplier
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [63:0]         mul_r;
  logic [71:0]         comb_sum;

  // step datapath
  logic [ERR_W-1:0]    err;
  logic [GYRO_W:0]     gy;
  logic [GYRO_W:0]     gy_abs;
  logic [TERM_W-1:0]   b_s;
  logic [TERM_W-1:0]   c_s;
  logic [TERM_W-1:0]   d_s;
  logic [TERM_W-1:0]   term_abs;
  logic [TERM_W-1:0]   prod_s;
  logic                next_fits;
  logic [ANGLE_W-1:0]  next_sat;
  logic                out_free;
  logic                commit;

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_filtered_angle = out_angle_r;
  assign out_free           = !out_valid_r || out_ready;
  // final step hands its result to the output register this cycle, once that register is free
  assign commit             = (state_r == S_SAT) && out_free;

  // operand select for the multiplier, per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_ERR: begin
        mul_a = {8'd0, tc_r};
        mul_b = {8'd0, tc_r};
      end
      S_C0: begin
        mul_a = err_mag_r[31:0];
        mul_b = {8'd0, tc_r};
      end
      S_C1: begin
        mul_a = {23'd0, err_mag_r[ERR_W-1:32]};
        mul_b = {8'd0, tc_r};
      end
      S_C2: begin
        mul_a = err_mag_r[31:0];
        mul_b = {8'd0, tc2_r};
      end
      S_A1: begin
        mul_a = {23'd0, err_mag_r[ERR_W-1:32]};
        mul_b = {8'd0, tc2_r};
      end
      S_A2: begin
        mul_a = {16'd0, gy_mag_r};
        mul_b = gain_r;
      end
      S_D: begin
        mul_a = a_mag_r[31:0];
        mul_b = {16'd0, dt_r};
      end
      S_B1: begin
        mul_a = {24'd0, a_mag_r[ANGLE_W-1:32]};
        mul_b = {16'd0, dt_r};
      end
      S_M0: begin
        mul_a = tmag_r[31:0];
        mul_b = {16'd0, dt_r};
      end
      S_M1: begin
        mul_a = {23'd0, tmag_r[TMAG_W-1:32]};
        mul_b = {16'd0, dt_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // joins the high and low partial products of a 41-bit operand
  assign comb_sum = {mul_r[39:0], 32'd0} + {8'd0, lo_r};

  // error and offset-corrected gyro (offset minus raw rate)
  assign err    = {acc_in_r[ACC_W-1], acc_in_r, {FRAC_W{1'b0}}}
                - {fused_r[ANGLE_W-1], fused_r};
  assign gy     = {offset_r[OFFSET_W-1], offset_r} - {gyro_in_r[GYRO_W-1], gyro_in_r};
  assign gy_abs = gy[GYRO_W] ? (~gy + 17'd1) : gy;

  // signed terms for the sum
  assign b_s = err_neg_r ? (~{3'd0, comb_sum[55:0]} + 59'd1) : {3'd0, comb_sum[55:0]};
  assign c_s = err_neg_r ? (~{18'd0, c_mag_r} + 59'd1) : {18'd0, c_mag_r};
  assign d_s = gy_neg_r ? (~{27'd0, d_mag_r} + 59'd1) : {27'd0, d_mag_r};

  assign term_abs = term_r[TERM_W-1] ? (~term_r + 59'd1) : term_r;

  assign prod_s = tneg_r ? (~{2'd0, comb_sum[56:0]} + 59'd1) : {2'd0, comb_sum[56:0]};

  // saturate to Q24.16
  assign next_fits = (&next_r[TERM_W-1:ANGLE_W-1]) | ~(|next_r[TERM_W-1:ANGLE_W-1]);
  assign next_sat  = next_fits ? next_r[ANGLE_W-1:0]
                   : (next_r[TERM_W-1] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                       : {1'b0, {(ANGLE_W-1){1'b1}}});

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      offset_r    <= OFFSET_RST;
      tc_r        <= TC_RST;
      gain_r      <= GAIN_RST;
      fused_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GYRO_OFFSET:   offset_r <= cfg_wdata[OFFSET_W-1:0];
          REG_TIME_CONSTANT: tc_r     <= cfg_wdata[TC_W-1:0];
          REG_GYRO_GAIN:     gain_r   <= cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && !commit) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            acc_in_r  <= in_accel_angle;
            gyro_in_r <= in_gyro_raw;
            dt_r      <= in_elapsed_ms;
            state_r   <= S_ERR;
          end
        end
        S_ERR: begin
          err_neg_r <= err[ERR_W-1];
          err_mag_r <= err[ERR_W-1] ? (~err + 41'd1) : err;
          gy_neg_r  <= gy[GYRO_W];
          gy_mag_r  <= gy_abs[GYRO_W-1:0];
          state_r   <= S_C0;
        end
        S_C0: begin
          tc2_r   <= mul_r[47:24];
          state_r <= S_C1;
        end
        S_C1: begin
          lo_r    <= mul_r;
          state_r <= S_C2;
        end
        S_C2: begin
          c_mag_r <= comb_sum[63:23];   // err*2*tc
          state_r <= S_A1;
        end
        S_A1: begin
          lo_r    <= mul_r;
          state_r <= S_A2;
        end
        S_A2: begin
          a_mag_r <= comb_sum[63:24];   // err*tc^2
          state_r <= S_D;
        end
        S_D: begin
          d_mag_r <= mul_r[47:16];      // gyro*gain
          state_r <= S_B1;
        end
        S_B1: begin
          lo_r    <= mul_r;
          state_r <= S_B2;
        end
        S_B2: begin
          term_r  <= b_s + c_s + d_s;
          state_r <= S_T;
        end
        S_T: begin
          tneg_r  <= term_r[TERM_W-1];
          tmag_r  <= (term_abs > {18'd0, TERM_LIM}) ? TERM_LIM : term_abs[TMAG_W-1:0];
          state_r <= S_M0;
        end
        S_M0: begin
          state_r <= S_M1;
        end
        S_M1: begin
          lo_r    <= mul_r;
          state_r <= S_M2;
        end
        S_M2: begin
          next_r  <= {{(TERM_W-ANGLE_W){fused_r[ANGLE_W-1]}}, fused_r} + prod_s;
          state_r <= S_SAT;
        end
        S_SAT: begin
          // hold here while the previous result is still waiting
          if (commit) begin
            fused_r     <= next_sat;
            out_angle_r <= int_part(next_sat);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a sample is in progress");

  a_result_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_SAT))
    else $error("result raised outside the final step");

  a_term_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_M0) |-> (tmag_r <= TERM_LIM))
    else $error("term magnitude above clamp limit");

  a_out_matches_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_angle_r == int_part(fused_r)))
    else $error("pending result does not match stored angle");

  a_angle_only_in_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SAT) |=> $stable(fused_r))
    else $error("angle changed outside the final step");
`endif

endmodule
